// ----- hw/rtl/tsse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-series stability estimator package
// Shared field widths, fixed scaling constants and the sequencer state type.
// ----------------------------------------------------------------------------
package tsse_pkg;

    // Fixed field widths of the streams and the configuration register.
    localparam int IN_W        = 32;
    localparam int TAU_W       = 17;
    localparam int MEAN_W      = 48;
    localparam int HAD_W       = 43;
    localparam int NOUT_W      = 24;
    localparam int OUT_TDATA_W = 120;
    localparam int OUT_TUSER_W = 2;

    // Accumulator widths and the fraction shift applied before division.
    localparam int ABS_W   = 56;
    localparam int SQS_W   = 128;
    localparam int FRAC_SH = 16;
    localparam int DVD_W   = SQS_W + FRAC_SH;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_M_LOAD,
        ST_M_MUL,
        ST_M_DLOAD,
        ST_M_DIV,
        ST_H_LOAD,
        ST_T2_MUL,
        ST_D_LOAD,
        ST_D_MUL,
        ST_H_DLOAD,
        ST_H_DIV,
        ST_R_LOAD,
        ST_SQRT,
        ST_OUT
    } state_t;

endpackage

// ----- hw/rtl/time_series_stability_estimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-series stability estimator
// Accumulates first and third differences of time readings and reports the
// mean frequency deviation and the Hadamard deviation at the end of a set.
// ----------------------------------------------------------------------------
// Usage:
//   Readings enter on the s_ stream, one per transfer; s_tlast marks the final
//   reading of a set. One result per set leaves on the m_ stream. The user
//   must write the sampling interval in seconds through cfg_we / cfg_wdata
//   only while idle; the block itself does not enforce this. All arithmetic
//   runs on one shift-add multiplier, one restoring divider and one
//   digit-by-digit square root, each producing one result bit per cycle.
//   With three or more readings before it in the set, a reading holds
//   s_tready low while its third difference is squared on the MB_W-bit
//   multiplier (MB_W = max(SAMPLE_BITS + 2, 17, COUNT_BITS), 34 by default).
//   A set of four or more finishes with the mean multiply, the Hadamard
//   multiplies, the two 144-step divisions and the square root.
//   Reset clears the set state, sets the interval to 1 and empties the output.
//   The result sits in an output register; a stalled receiver does not stop
//   new readings, only the finish of the next set until the result is taken.
// ----------------------------------------------------------------------------
module time_series_stability_estimator #(
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS  = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration: sampling interval in seconds.
    input  logic                              cfg_we,
    input  logic [tsse_pkg::TAU_W-1:0]        cfg_wdata,
    // Readings. tdata: sample_value[31:0].
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tsse_pkg::IN_W-1:0]         s_tdata,
    input  logic                              s_tlast,
    // Results. tdata: mean_frequency_deviation[47:0],
    // hadamard_deviation[90:48], samples_seen[114:91], zero fill.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tsse_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // tuser: stability_valid[0], count_overflow[1].
    output logic [tsse_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import tsse_pkg::*;

    localparam int XW     = (SAMPLE_BITS > IN_W) ? SAMPLE_BITS : IN_W;
    localparam int NW     = (COUNT_BITS > NOUT_W) ? COUNT_BITS : NOUT_W;
    localparam int MAG_W  = SAMPLE_BITS + 2;
    localparam int T6_W   = 2 * TAU_W + 3;
    localparam int DIVR_W = T6_W + COUNT_BITS;
    localparam int PROD_W = (DIVR_W > 2 * MAG_W) ? DIVR_W : 2 * MAG_W;
    localparam int MB_A   = (MAG_W > TAU_W) ? MAG_W : TAU_W;
    localparam int MB_W   = (MB_A > COUNT_BITS) ? MB_A : COUNT_BITS;
    localparam int CNT_W  = $clog2(DVD_W + 1);
    localparam int SR_W   = HAD_W + 3;
    localparam int SQ_SH  = DVD_W - 2 * HAD_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    state_t state_reg, state_next;

    logic [TAU_W-1:0]       tau_reg;
    logic [SAMPLE_BITS-1:0] hist0_reg, hist1_reg, hist2_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic                   ovf_reg;
    logic                   last_reg;
    logic [ABS_W-1:0]       abs_reg;
    logic [SQS_W-1:0]       sq_reg;
    logic [PROD_W-1:0]      mul_a_reg, prod_reg;
    logic [MB_W-1:0]        mul_b_reg;
    logic [DIVR_W-1:0]      div_d_reg, rem_reg;
    logic [DVD_W-1:0]       quo_reg;
    logic [HAD_W:0]         srem_reg;
    logic [HAD_W-1:0]       root_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [MEAN_W-1:0]      mean_reg;

    logic                   out_valid_reg;
    logic [MEAN_W-1:0]      out_mean_reg;
    logic [HAD_W-1:0]       out_had_reg;
    logic [NOUT_W-1:0]      out_n_reg;
    logic                   out_stab_reg;
    logic                   out_ovf_reg;

    // Per-reading arithmetic on the incoming value.
    logic [XW-1:0]          x_ext;
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] abs_diff;
    logic [ABS_W:0]         abs_sum;
    logic [MAG_W-1:0]       pos_part, neg_part, d3_mag;
    logic                   accept;

    assign x_ext    = XW'(s_tdata);
    assign x        = x_ext[SAMPLE_BITS-1:0];
    assign abs_diff = (x >= hist0_reg) ? (x - hist0_reg) : (hist0_reg - x);
    assign abs_sum  = {1'b0, abs_reg} + (ABS_W + 1)'(abs_diff);
    assign pos_part = MAG_W'(x) + MAG_W'({hist1_reg, 1'b0}) + MAG_W'(hist1_reg);
    assign neg_part = MAG_W'({hist0_reg, 1'b0}) + MAG_W'(hist0_reg) + MAG_W'(hist2_reg);
    assign d3_mag   = (pos_part >= neg_part) ? (pos_part - neg_part)
                                             : (neg_part - pos_part);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Shared unit steps.
    logic [TAU_W-1:0]   tau_eff;
    logic [SQS_W:0]     sq_sum;
    logic [PROD_W-1:0]  t6;
    logic [DIVR_W:0]    div_t;
    logic               div_ge;
    logic [SR_W-1:0]    sr_t, sr_trial;
    logic               sr_ge;
    logic               mul_done, div_done, sqrt_done, out_free;

    assign tau_eff  = (tau_reg == '0) ? TAU_W'(1) : tau_reg;
    assign sq_sum   = {1'b0, sq_reg} + (SQS_W + 1)'(prod_reg);
    assign t6       = {prod_reg[PROD_W-3:0], 2'b00} + {prod_reg[PROD_W-2:0], 1'b0};
    assign div_t    = {rem_reg, quo_reg[DVD_W-1]};
    assign div_ge   = div_t >= {1'b0, div_d_reg};
    assign sr_t     = {srem_reg, quo_reg[DVD_W-1:DVD_W-2]};
    assign sr_trial = SR_W'({root_reg, 2'b01});
    assign sr_ge    = sr_t >= sr_trial;
    assign mul_done  = (cnt_reg == CNT_W'(MB_W - 1));
    assign div_done  = (cnt_reg == CNT_W'(DVD_W - 1));
    assign sqrt_done = (cnt_reg == CNT_W'(HAD_W - 1));
    assign out_free  = !out_valid_reg || m_tready;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg >= COUNT_BITS'(3))
                        state_next = ST_SQ_MUL;
                    else if (s_tlast)
                        state_next = ST_M_LOAD;
                end
            end
            ST_SQ_MUL:  if (mul_done) state_next = ST_SQ_ADD;
            ST_SQ_ADD:  state_next = last_reg ? ST_M_LOAD : ST_IDLE;
            ST_M_LOAD:  state_next = ST_M_MUL;
            ST_M_MUL:   if (mul_done) state_next = ST_M_DLOAD;
            ST_M_DLOAD: state_next = ST_M_DIV;
            ST_M_DIV:   if (div_done) state_next = ST_H_LOAD;
            ST_H_LOAD:  state_next = (count_reg >= COUNT_BITS'(4)) ? ST_T2_MUL : ST_OUT;
            ST_T2_MUL:  if (mul_done) state_next = ST_D_LOAD;
            ST_D_LOAD:  state_next = ST_D_MUL;
            ST_D_MUL:   if (mul_done) state_next = ST_H_DLOAD;
            ST_H_DLOAD: state_next = ST_H_DIV;
            ST_H_DIV:   if (div_done) state_next = ST_R_LOAD;
            ST_R_LOAD:
            begin
                if (quo_reg[DVD_W-1:2*HAD_W] != '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_SQRT;
            end
            ST_SQRT:    if (sqrt_done) state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Interval register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tau_reg <= TAU_W'(1);
        else if (cfg_we)
            tau_reg <= cfg_wdata;
    end

    // Set state: history, count, sums and overflow flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist0_reg <= '0;
            hist1_reg <= '0;
            hist2_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
            abs_reg   <= '0;
            sq_reg    <= '0;
        end
        else if (accept)
        begin
            hist0_reg <= x;
            hist1_reg <= hist0_reg;
            hist2_reg <= hist1_reg;
            last_reg  <= s_tlast;
            if (count_reg == COUNT_MAX)
                ovf_reg <= 1'b1;
            else
                count_reg <= count_reg + COUNT_BITS'(1);
            if (count_reg != '0)
                abs_reg <= abs_sum[ABS_W] ? {ABS_W{1'b1}} : abs_sum[ABS_W-1:0];
        end
        else if (state_reg == ST_SQ_ADD)
            sq_reg <= sq_sum[SQS_W] ? {SQS_W{1'b1}} : sq_sum[SQS_W-1:0];
        else if (state_reg == ST_OUT && out_free)
        begin
            hist0_reg <= '0;
            hist1_reg <= '0;
            hist2_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            abs_reg   <= '0;
            sq_reg    <= '0;
        end
    end

    // Shared multiplier, divider and square root datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mul_a_reg <= PROD_W'(d3_mag);
                mul_b_reg <= MB_W'(d3_mag);
                prod_reg  <= '0;
                cnt_reg   <= '0;
            end
            ST_SQ_MUL, ST_M_MUL, ST_T2_MUL, ST_D_MUL:
            begin
                if (mul_b_reg[0])
                    prod_reg <= prod_reg + mul_a_reg;
                mul_a_reg <= {mul_a_reg[PROD_W-2:0], 1'b0};
                mul_b_reg <= {1'b0, mul_b_reg[MB_W-1:1]};
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
            ST_M_LOAD:
            begin
                mul_a_reg <= PROD_W'(tau_eff);
                mul_b_reg <= MB_W'(count_reg);
                prod_reg  <= '0;
                cnt_reg   <= '0;
            end
            ST_M_DLOAD:
            begin
                div_d_reg <= prod_reg[DIVR_W-1:0];
                quo_reg   <= DVD_W'({abs_reg, {FRAC_SH{1'b0}}});
                rem_reg   <= '0;
                cnt_reg   <= '0;
            end
            ST_M_DIV, ST_H_DIV:
            begin
                rem_reg <= div_ge ? div_t[DIVR_W-1:0] - div_d_reg : div_t[DIVR_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], div_ge};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_H_LOAD:
            begin
                mean_reg  <= (quo_reg[DVD_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}}
                                                             : quo_reg[MEAN_W-1:0];
                root_reg  <= '0;
                mul_a_reg <= PROD_W'(tau_eff);
                mul_b_reg <= MB_W'(tau_eff);
                prod_reg  <= '0;
                cnt_reg   <= '0;
            end
            ST_D_LOAD:
            begin
                mul_a_reg <= t6;
                mul_b_reg <= MB_W'(count_reg - COUNT_BITS'(3));
                prod_reg  <= '0;
                cnt_reg   <= '0;
            end
            ST_H_DLOAD:
            begin
                div_d_reg <= prod_reg[DIVR_W-1:0];
                quo_reg   <= {sq_reg, {FRAC_SH{1'b0}}};
                rem_reg   <= '0;
                cnt_reg   <= '0;
            end
            ST_R_LOAD:
            begin
                // A quotient past the square of the output range clamps at once.
                root_reg <= {HAD_W{1'b1}};
                if (quo_reg[DVD_W-1:2*HAD_W] == '0)
                    root_reg <= '0;
                quo_reg  <= {quo_reg[DVD_W-SQ_SH-1:0], {SQ_SH{1'b0}}};
                srem_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_SQRT:
            begin
                srem_reg <= sr_ge ? (HAD_W + 1)'(sr_t - sr_trial) : (HAD_W + 1)'(sr_t);
                root_reg <= {root_reg[HAD_W-2:0], sr_ge};
                quo_reg  <= {quo_reg[DVD_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // Output register.
    logic [NW-1:0] n_ext;
    assign n_ext = NW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_mean_reg <= mean_reg;
            out_had_reg  <= root_reg;
            out_n_reg    <= n_ext[NOUT_W-1:0];
            out_stab_reg <= (count_reg >= COUNT_BITS'(4));
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - MEAN_W - HAD_W - NOUT_W){1'b0}},
                       out_n_reg, out_had_reg, out_mean_reg};
    assign m_tuser  = {out_ovf_reg, out_stab_reg};

    // Checks on the sequencer.
    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == COUNT_MAX))
        else $error("overflow flag set below the count limit");

    a_last_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg != ST_IDLE))
        else $error("final reading did not start the finish sequence");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_M_DIV || state_reg == ST_H_DIV) |-> (div_d_reg != '0))
        else $error("divider running with a zero divisor");

    a_had_needs_four: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_T2_MUL) |-> (count_reg >= COUNT_BITS'(4)))
        else $error("Hadamard path entered with fewer than four readings");

endmodule
